@@ sv/mrr_pkg.sv @@
// Shared types and constants for the mask run-to-rectangle block.
package mrr_pkg;

  localparam int COORD_W  = 16;   // device coordinate width
  localparam int EXT_W    = 17;   // coordinate plus one guard bit
  localparam int ROW_W    = 64;   // mask row width in the store
  localparam int COL_W    = 7;    // column index, holds 0..64
  localparam int S_DATA_W = 120;  // slave tdata width
  localparam int S_USER_W = 2;    // slave tuser width
  localparam int M_DATA_W = 64;   // master tdata width
  localparam int CFG_AW   = 4;    // APB address width
  localparam int CFG_DW   = 32;   // APB data width

  localparam logic [1:0] REG_PHASE_X     = 2'd0;
  localparam logic [1:0] REG_PHASE_Y     = 2'd1;
  localparam logic [1:0] REG_MASK_WIDTH  = 2'd2;
  localparam logic [1:0] REG_MASK_HEIGHT = 2'd3;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_SCAN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_RUN,
    ST_FLUSH,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
  } rect_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [COL_W-1:0] low_idx(input logic [ROW_W:0] x);
    logic [ROW_W:0] one;
    logic [COL_W-1:0] idx;
    one = x & (~x + {{ROW_W{1'b0}}, 1'b1});
    idx = '0;
    for (int i = 0; i <= ROW_W; i++) begin
      if (one[i]) idx = idx | COL_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ sv/mask_runs_to_rectangles.sv @@
// Clip-mask store and run-to-rectangle merger, top level.
//
// A 1-bit clip mask sits in a synchronous row memory, loaded one row per
// slave transaction (tuser action = load). A scan transaction names a device
// row and a span; the span is clipped to the mask through the phase
// registers, each run of set bits becomes a rectangle, and runs that repeat
// the pending rectangle's x extent on the next row extend it downward.
// Rectangles leave on the master stream; tlast marks the final rectangle of
// one scan. Phase and mask size are set over the APB port; the user must do so
// only while idle, as the block itself does not enforce it. A load is written
// to the row memory when accepted. A scan runs through these steps in order:
// accept and memory read, building the run edge vectors, one run per cycle
// through the edge priority encoders (held while an emit waits on full
// registers), an empty check, the last-row flush and the hand-off of the held
// rectangle. One item is worked at a time. A rectangle waits in a hold
// register until the next one is emitted or the scan ends, then moves on out.
// When the receiver stalls, run processing holds once both registers are
// full; nothing is dropped. Reset clears the pending rectangle, the
// registers (phase 0, width 64, height 256) and all handshakes; mask rows
// hold no defined value until loaded.
module mask_runs_to_rectangles #(
  parameter int MASK_ROWS = 256,
  parameter int MASK_COLS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // row_index[7:0], row_bits[71:8], dev_y[87:72], span_x0[103:88], span_x1[119:104]
  input  logic [mrr_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // action[0], first_row[1]
  input  logic [mrr_pkg::S_USER_W-1:0]     s_axis_tuser,
  input  logic                             s_axis_tlast,
  // master stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // rect_x0[15:0], rect_y0[31:16], rect_x1[47:32], rect_y1[63:48]
  output logic [mrr_pkg::M_DATA_W-1:0]     m_axis_tdata,
  output logic                             m_axis_tlast,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mrr_pkg::CFG_AW-1:0]       paddr,
  input  logic [mrr_pkg::CFG_DW-1:0]       pwdata,
  output logic [mrr_pkg::CFG_DW-1:0]       prdata,
  output logic                             pready
);
  import mrr_pkg::*;

  localparam int AW = (MASK_ROWS > 1) ? $clog2(MASK_ROWS) : 1;

  // input fields
  logic                 in_action, in_first, in_last;
  logic [7:0]           in_row_index;
  logic [ROW_W-1:0]     in_row_bits;
  logic [COORD_W-1:0]   in_dev_y, in_x0, in_x1;

  assign in_row_index = s_axis_tdata[7:0];
  assign in_row_bits  = s_axis_tdata[71:8];
  assign in_dev_y     = s_axis_tdata[87:72];
  assign in_x0        = s_axis_tdata[103:88];
  assign in_x1        = s_axis_tdata[119:104];
  assign in_action    = s_axis_tuser[0];
  assign in_first     = s_axis_tuser[1];
  assign in_last      = s_axis_tlast;

  // configuration registers
  logic [COORD_W-1:0] phase_x_q, phase_y_q;
  logic [COL_W-1:0]   mask_width_q;
  logic [8:0]         mask_height_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_x_q     <= '0;
      phase_y_q     <= '0;
      mask_width_q  <= 7'd64;
      mask_height_q <= 9'd256;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_PHASE_X:     phase_x_q     <= pwdata[15:0];
        REG_PHASE_Y:     phase_y_q     <= pwdata[15:0];
        REG_MASK_WIDTH:  mask_width_q  <= pwdata[6:0];
        REG_MASK_HEIGHT: mask_height_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PHASE_X:     prdata = {16'd0, phase_x_q};
      REG_PHASE_Y:     prdata = {16'd0, phase_y_q};
      REG_MASK_WIDTH:  prdata = {25'd0, mask_width_q};
      REG_MASK_HEIGHT: prdata = {23'd0, mask_height_q};
      default:         prdata = '0;
    endcase
  end

  // state and working registers
  state_e               state_q, state_d;
  logic [ROW_W-1:0]     mem_q [MASK_ROWS];
  logic [ROW_W-1:0]     rd_data_q;
  logic [COORD_W-1:0]   dev_y_q, ybot_q;
  logic [COL_W-1:0]     mx0_q, mx1_q;
  logic                 hit_q, last_row_q;
  logic [ROW_W:0]       starts_q, ends_q;
  logic signed [EXT_W-1:0] pend_x0_q, pend_x1_q;
  logic [COORD_W-1:0]   pend_y0_q, pend_y1_q;
  logic                 pend_v_q;
  rect_t                hold_q, out_q;
  logic                 hold_v_q, out_v_q, out_last_q;

  // scan setup arithmetic
  logic signed [EXT_W-1:0] px_s, my_s, mx0_s, mx1_s, cols_s, mx0_c, mx1_c;
  logic [EXT_W-1:0]     rows_eff;
  logic [COL_W-1:0]     cols_eff;
  logic                 my_ok, span_ok;

  assign px_s   = $signed({phase_x_q[COORD_W-1], phase_x_q});
  assign my_s   = $signed({in_dev_y[COORD_W-1], in_dev_y})
                + $signed({phase_y_q[COORD_W-1], phase_y_q});
  assign mx0_s  = $signed({in_x0[COORD_W-1], in_x0}) + px_s;
  assign mx1_s  = $signed({in_x1[COORD_W-1], in_x1}) + px_s;
  assign cols_eff = (mask_width_q > COL_W'(MASK_COLS)) ? COL_W'(MASK_COLS) : mask_width_q;
  assign cols_s = $signed({{(EXT_W-COL_W){1'b0}}, cols_eff});
  assign rows_eff = (EXT_W'(mask_height_q) > EXT_W'(MASK_ROWS)) ?
                    EXT_W'(MASK_ROWS) : EXT_W'(mask_height_q);
  assign mx0_c  = mx0_s[EXT_W-1] ? '0 : mx0_s;
  assign mx1_c  = (mx1_s > cols_s) ? cols_s : mx1_s;
  assign my_ok  = !my_s[EXT_W-1] && ($unsigned(my_s) < rows_eff);
  assign span_ok = mx0_c < mx1_c;

  // run edge vectors from the fetched row
  logic [ROW_W-1:0] vis;
  logic [ROW_W:0]   starts_d, ends_d;

  always_comb begin
    for (int c = 0; c < ROW_W; c++) begin
      vis[c] = hit_q && rd_data_q[ROW_W-1-c]
               && (COL_W'(c) >= mx0_q) && (COL_W'(c) < mx1_q);
    end
    starts_d = '0;
    ends_d   = '0;
    starts_d[0] = vis[0];
    for (int c = 1; c < ROW_W; c++) begin
      starts_d[c] = vis[c] && !vis[c-1];
      ends_d[c]   = vis[c-1] && !vis[c];
    end
    ends_d[ROW_W] = vis[ROW_W-1];
  end

  // one run per cycle while an emitted rectangle can be taken
  logic [COL_W-1:0]        run_a, run_c;
  logic signed [EXT_W-1:0] tx0, tx1;
  logic                    runs_left, merge;

  assign run_a = low_idx(starts_q);
  assign run_c = low_idx(ends_q);
  assign tx0   = $signed({{(EXT_W-COL_W){1'b0}}, run_a}) - px_s;
  assign tx1   = $signed({{(EXT_W-COL_W){1'b0}}, run_c}) - px_s;
  assign runs_left = |starts_q;
  assign merge = pend_v_q && (pend_x0_q == tx0) && (pend_x1_q == tx1)
                 && (pend_y1_q == dev_y_q);

  // control
  logic accept, is_scan, out_free, can_emit;
  logic need_emit_run, run_go, flush_emit, flush_go, fin_go;
  logic emit, push_out, push_last;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_scan  = (in_action == ACT_SCAN);
  assign out_free = !out_v_q || m_axis_tready;
  assign can_emit = !hold_v_q || out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept && is_scan) state_d = ST_BUILD;
      ST_BUILD: state_d = ST_RUN;
      ST_RUN:   if (!runs_left) state_d = ST_FLUSH;
      ST_FLUSH: if (flush_go) state_d = ST_FIN;
      ST_FIN:   if (fin_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    need_emit_run = 1'b0;
    run_go        = 1'b0;
    flush_emit    = 1'b0;
    flush_go      = 1'b0;
    fin_go        = 1'b0;
    emit          = 1'b0;
    push_out      = 1'b0;
    push_last     = 1'b0;
    case (state_q)
      ST_RUN: begin
        need_emit_run = runs_left && pend_v_q && !merge;
        run_go        = runs_left && (!need_emit_run || can_emit);
        emit          = run_go && need_emit_run;
        push_out      = emit && hold_v_q;
      end
      ST_FLUSH: begin
        flush_emit = last_row_q && pend_v_q;
        flush_go   = !flush_emit || can_emit;
        emit       = flush_emit && flush_go;
        push_out   = emit && hold_v_q;
      end
      ST_FIN: begin
        fin_go    = !hold_v_q || out_free;
        push_out  = hold_v_q && out_free;
        push_last = 1'b1;
      end
      default: ;
    endcase
  end

  // mask memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (accept && !is_scan && (13'(in_row_index) < 13'(MASK_ROWS))) begin
      mem_q[AW'(in_row_index)] <= in_row_bits;
    end
    if (accept && is_scan) begin
      rd_data_q <= mem_q[my_s[AW-1:0]];
    end
  end

  // scan item and run vectors
  always_ff @(posedge clk_i) begin
    if (accept && is_scan) begin
      dev_y_q    <= in_dev_y;
      ybot_q     <= in_dev_y + 16'd1;
      mx0_q      <= mx0_c[COL_W-1:0];
      mx1_q      <= mx1_c[COL_W-1:0];
      hit_q      <= my_ok && span_ok;
      last_row_q <= in_last;
    end
    if (state_q == ST_BUILD) begin
      starts_q <= starts_d;
      ends_q   <= ends_d;
    end else if (run_go) begin
      // drop the run just taken
      starts_q <= starts_q & (starts_q - {{ROW_W{1'b0}}, 1'b1});
      ends_q   <= ends_q & (ends_q - {{ROW_W{1'b0}}, 1'b1});
    end
    if (emit) begin
      hold_q <= '{x0: pend_x0_q[COORD_W-1:0], y0: pend_y0_q,
                  x1: pend_x1_q[COORD_W-1:0], y1: pend_y1_q};
    end
    if (push_out) begin
      out_q      <= hold_q;
      out_last_q <= push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pend_x0_q <= '0;
      pend_x1_q <= '0;
      pend_y0_q <= '0;
      pend_y1_q <= '0;
      pend_v_q  <= 1'b0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && is_scan && in_first) begin
        pend_v_q <= 1'b0;
      end else if (run_go) begin
        if (merge) begin
          pend_y1_q <= ybot_q;
        end else begin
          pend_x0_q <= tx0;
          pend_x1_q <= tx1;
          pend_y0_q <= dev_y_q;
          pend_y1_q <= ybot_q;
          pend_v_q  <= 1'b1;
        end
      end else if (emit) begin
        pend_v_q <= 1'b0;
      end
      if (emit) begin
        hold_v_q <= 1'b1;
      end else if ((state_q == ST_FIN) && fin_go) begin
        hold_v_q <= 1'b0;
      end
      if (push_out) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.y1, out_q.x1, out_q.y0, out_q.x0};
  assign m_axis_tlast  = out_last_q;

endmodule

@@ tb/mask_runs_to_rectangles_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench: mask loads and row scans checked against an in-bench rectangle merger.
module mask_runs_to_rectangles_tb;
  import mrr_pkg::*;

  localparam int          CLK_HALF      = 5;
  localparam int          LIMIT_CYCLES  = 1_000_000;
  localparam int          SETTLE_CYCLES = 48;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          N_ROWS        = 256;
  localparam int          N_COLS        = 64;
  localparam int          MAX_PRINTS    = 30;
  localparam logic [63:0] ALT_ROW       = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef struct {
    logic               act;
    logic [7:0]         row_index;
    logic [63:0]        row_bits;
    logic signed [15:0] dev_y;
    logic signed [15:0] span_x0;
    logic signed [15:0] span_x1;
    logic               first_row;
    logic               last_row;
  } clip_item_t;

  typedef struct {
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic        last;
  } rect_exp_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [S_USER_W-1:0] s_axis_tuser  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [CFG_AW-1:0]   paddr         = '0;
  logic [CFG_DW-1:0]   pwdata        = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  // Mirror of the block: mask rows, pending rectangle, registers.
  logic [63:0] mask_rows [N_ROWS];
  bit          row_loaded [N_ROWS];
  int          pend_x0, pend_y0, pend_x1, pend_y1;
  bit          pend_on     = 1'b0;
  int          cur_phase_x = 0;
  int          cur_phase_y = 0;
  int          cur_width   = 64;
  int          cur_height  = 256;
  rect_exp_t   rect_due [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_off       = 1'b0;
  int err_cnt        = 0;
  int scans_sent     = 0;
  int loads_sent     = 0;
  int rects_seen     = 0;
  int cycle_cnt      = 0;

  mask_runs_to_rectangles u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) begin
      $display("ERROR %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    end
  endtask

  always @(posedge clk_i) begin : rect_check
    rect_exp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rects_seen++;
      if (rect_due.size() == 0) begin
        report("rectangle with none expected", m_axis_tdata, '0);
      end else begin
        want = rect_due.pop_front();
        if (m_axis_tdata[15:0] !== want.x0)
          report("rect_x0", 64'(m_axis_tdata[15:0]), 64'(want.x0));
        if (m_axis_tdata[31:16] !== want.y0)
          report("rect_y0", 64'(m_axis_tdata[31:16]), 64'(want.y0));
        if (m_axis_tdata[47:32] !== want.x1)
          report("rect_x1", 64'(m_axis_tdata[47:32]), 64'(want.x1));
        if (m_axis_tdata[63:48] !== want.y1)
          report("rect_y1", 64'(m_axis_tdata[63:48]), 64'(want.y1));
        if (m_axis_tlast !== want.last)
          report("last", 64'(m_axis_tlast), 64'(want.last));
      end
    end
  end

  function automatic void push_rect(input int x0, input int y0, input int x1, input int y1);
    rect_exp_t r;
    r.x0   = 16'(x0);
    r.y0   = 16'(y0);
    r.x1   = 16'(x1);
    r.y1   = 16'(y1);
    r.last = 1'b0;
    rect_due.push_back(r);
  endfunction

  // Clip the span through the phase, walk the runs, merge or emit.
  function automatic void merge_runs(input clip_item_t it);
    int                 cols, rows, my, mx0, mx1, c, a, tx0, tx1, dy, ybot, n;
    logic signed [15:0] yb16;
    logic [63:0]        bits;
    n = 0;
    if (it.act == ACT_LOAD) begin
      mask_rows[it.row_index]  = it.row_bits;
      row_loaded[it.row_index] = 1'b1;
      return;
    end
    dy = int'(it.dev_y);
    if (it.first_row) pend_on = 1'b0;
    cols = (cur_width > N_COLS) ? N_COLS : cur_width;
    rows = (cur_height > N_ROWS) ? N_ROWS : cur_height;
    my   = dy + cur_phase_y;
    mx0  = int'(it.span_x0) + cur_phase_x;
    mx1  = int'(it.span_x1) + cur_phase_x;
    if (mx0 < 0) mx0 = 0;
    if (mx1 > cols) mx1 = cols;
    if (my >= 0 && my < rows && mx0 < mx1) begin
      bits = mask_rows[8'(my)];
      yb16 = 16'(dy + 1);
      ybot = int'(yb16);
      c    = mx0;
      while (c < mx1) begin
        while (c < mx1 && !bits[63-c]) c++;
        if (c >= mx1) break;
        a = c;
        while (c < mx1 && bits[63-c]) c++;
        tx0 = a - cur_phase_x;
        tx1 = c - cur_phase_x;
        if (pend_on && pend_x0 == tx0 && pend_x1 == tx1 && pend_y1 == dy) begin
          pend_y1 = ybot;
        end else begin
          if (pend_on) begin
            push_rect(pend_x0, pend_y0, pend_x1, pend_y1);
            n++;
          end
          pend_x0 = tx0;
          pend_y0 = dy;
          pend_x1 = tx1;
          pend_y1 = ybot;
          pend_on = 1'b1;
        end
      end
    end
    if (it.last_row && pend_on) begin
      push_rect(pend_x0, pend_y0, pend_x1, pend_y1);
      n++;
      pend_on = 1'b0;
    end
    if (n > 0) rect_due[rect_due.size()-1].last = 1'b1;
  endfunction

  task automatic send_item(input clip_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.span_x1, it.span_x0, it.dev_y, it.row_bits, it.row_index};
    s_axis_tuser  <= {it.first_row, it.act};
    s_axis_tlast  <= it.last_row;
    do @(posedge clk_i); while (!s_axis_tready);
    merge_runs(it);
    if (it.act == ACT_SCAN) scans_sent++;
    else loads_sent++;
  endtask

  // Scan-only fields carry random values on a load.
  task automatic load_row(input logic [7:0] idx, input logic [63:0] bits);
    clip_item_t it;
    it.act       = ACT_LOAD;
    it.row_index = idx;
    it.row_bits  = bits;
    it.dev_y     = 16'($urandom);
    it.span_x0   = 16'($urandom);
    it.span_x1   = 16'($urandom);
    it.first_row = 1'($urandom);
    it.last_row  = 1'($urandom);
    send_item(it);
  endtask

  function automatic logic [63:0] rand_row();
    logic [63:0] r;
    int          a, len, k;
    case ($urandom_range(6))
      0: r = {$urandom, $urandom};
      1: r = '1;
      2: r = '0;
      3: r = ALT_ROW;
      default: begin
        r = '0;
        repeat ($urandom_range(1, 4)) begin
          a   = $urandom_range(63);
          len = $urandom_range(1, 16);
          for (k = a; k < a + len && k < N_COLS; k++) r[63-k] = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Load the addressed mask row first if it was never written.
  task automatic scan_row(input logic signed [15:0] dy, input logic signed [15:0] x0,
                          input logic signed [15:0] x1, input bit first, input bit last);
    clip_item_t it;
    int         my, rows;
    my   = int'(dy) + cur_phase_y;
    rows = (cur_height > N_ROWS) ? N_ROWS : cur_height;
    if (my >= 0 && my < rows && !row_loaded[8'(my)]) load_row(8'(my), rand_row());
    it.act       = ACT_SCAN;
    it.row_index = 8'($urandom);
    it.row_bits  = {$urandom, $urandom};
    it.dev_y     = dy;
    it.span_x0   = x0;
    it.span_x1   = x1;
    it.first_row = first;
    it.last_row  = last;
    send_item(it);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (rect_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PHASE_X:     cur_phase_x = int'($signed(val[15:0]));
      REG_PHASE_Y:     cur_phase_y = int'($signed(val[15:0]));
      REG_MASK_WIDTH:  cur_width   = int'(val[6:0]);
      REG_MASK_HEIGHT: cur_height  = int'(val[8:0]);
      default: ;
    endcase
  endtask

  task automatic set_cfg(input int px, input int py, input int w, input int h);
    set_reg(REG_PHASE_X, 32'(px));
    set_reg(REG_PHASE_Y, 32'(py));
    set_reg(REG_MASK_WIDTH, 32'(w));
    set_reg(REG_MASK_HEIGHT, 32'(h));
  endtask

  task automatic test_directed();
    load_row(8'd0, '1);
    load_row(8'd1, '1);
    load_row(8'd2, ALT_ROW);
    // merge two full rows, then flush
    scan_row(16'sd0, 16'sd0, 16'sd64, 1'b1, 1'b0);
    scan_row(16'sd1, 16'sd0, 16'sd64, 1'b0, 1'b1);
    // pending full row, then a 32-run row: most results one scan can cause
    scan_row(16'sd0, 16'sd0, 16'sd64, 1'b1, 1'b0);
    scan_row(16'sd2, -16'sd32768, 16'sd32767, 1'b0, 1'b1);
    // empty and reversed spans
    scan_row(16'sd255, 16'sd5, 16'sd5, 1'b1, 1'b1);
    scan_row(16'sd0, 16'sd10, 16'sd20, 1'b1, 1'b0);
    scan_row(16'sd1, 16'sd30, 16'sd12, 1'b0, 1'b1);
    // rows outside the mask; a load in between leaves the pending rectangle alone
    scan_row(16'sd0, 16'sd0, 16'sd8, 1'b1, 1'b0);
    scan_row(-16'sd1, 16'sd0, 16'sd64, 1'b0, 1'b0);
    load_row(8'd7, rand_row());
    scan_row(16'sd32767, 16'sd0, 16'sd64, 1'b0, 1'b1);
    // first_row drops the pending rectangle
    scan_row(16'sd0, 16'sd0, 16'sd64, 1'b1, 1'b0);
    scan_row(16'sd1, 16'sd0, 16'sd64, 1'b1, 1'b1);
    // phase extremes, bottom edge wrap, oversize width and height
    set_cfg(32767, -32767, 100, 300);
    scan_row(16'sd32767, -16'sd32768, 16'sd32767, 1'b1, 1'b1);
    scan_row(-16'sd32512, -16'sd32768, -16'sd32700, 1'b1, 1'b1);
    set_cfg(-32768, 32767, 0, 0);
    scan_row(-16'sd32767, -16'sd32768, 16'sd32767, 1'b1, 1'b1);
    set_reg(REG_MASK_HEIGHT, 32'd1);
    scan_row(-16'sd32767, -16'sd32768, 16'sd32767, 1'b1, 1'b1);
    set_cfg(0, 32767, 1, 1);
    scan_row(-16'sd32767, -16'sd5, 16'sd5, 1'b1, 1'b0);
    scan_row(-16'sd32766, -16'sd5, 16'sd5, 1'b0, 1'b1);
    set_reg(REG_MASK_WIDTH, 32'd127);
    set_reg(REG_MASK_HEIGHT, 32'd511);
    scan_row(-16'sd32767, -16'sd32768, 16'sd32767, 1'b1, 1'b1);
    set_cfg(0, 0, 64, 256);
  endtask

  // Stall the receiver long enough for the block to back up into its input.
  task automatic test_backpressure();
    int k;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_row(8'd3, ALT_ROW);
    load_row(8'd4, ~ALT_ROW);
    hold_off <= 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    for (k = 0; k < 6; k++) begin
      scan_row(16'(3 + k % 2), 16'sd0, 16'sd64, 1'b1, 1'b1);
    end
    wait_idle();
  endtask

  task automatic test_random_scans(input int n_scans);
    int done, my, rows, k, len;
    bit broken;
    logic signed [15:0] x0, x1;
    logic [63:0] pat;
    done = 0;
    while (done < n_scans) begin
      rows = (cur_height > N_ROWS) ? N_ROWS : cur_height;
      if ($urandom_range(99) < 20) begin
        // noise: arbitrary loads and scans
        if ($urandom_range(1)) begin
          load_row(8'($urandom), rand_row());
        end else begin
          scan_row(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
          done++;
        end
      end else begin
        len    = $urandom_range(1, 6);
        my     = ($urandom_range(9) == 0) ? rows + $urandom_range(3) : $urandom_range(rows - 1);
        pat    = rand_row();
        broken = ($urandom_range(9) == 0);
        for (k = 0; k < len; k++) begin
          if (my + k < N_ROWS) begin
            load_row(8'(my + k), ($urandom_range(3) == 0) ? rand_row() : pat);
          end
        end
        if ($urandom_range(4) == 0) begin
          x0 = -16'sd32768;
          x1 = 16'sd32767;
        end else begin
          x0 = 16'($urandom_range(24) - 8 - cur_phase_x);
          x1 = 16'($urandom_range(32, 72) - cur_phase_x);
        end
        for (k = 0; k < len; k++) begin
          scan_row(16'(my + k - cur_phase_y), x0, x1, k == 0 && !broken,
                   k == len - 1 && !broken);
          done++;
        end
      end
    end
  endtask

  task automatic test_idle_mix(input int send_pct, input int recv_pct);
    set_cfg($urandom_range(8) - 4, $urandom_range(200) - 100,
            ($urandom_range(2) == 0) ? 64 : $urandom_range(8, 64),
            ($urandom_range(1) == 0) ? 256 : $urandom_range(16, 256));
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    test_random_scans(12);
  endtask

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles with %0d rectangles outstanding",
             cycle_cnt, rect_due.size());
    $display("FAIL mask_runs_to_rectangles");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_idle_mix(0, 0);
    test_idle_mix(47, 0);
    test_idle_mix(0, 47);
    test_idle_mix(26, 26);
    wait_idle();
    $display("Covered %0d scan and %0d load transactions, %0d rectangles compared",
             scans_sent, loads_sent, rects_seen);
    $display("Included register extremes, a %0d-cycle output hold-off and four idle mixes",
             HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("PASS mask_runs_to_rectangles");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAIL mask_runs_to_rectangles");
    end
    $finish;
  end

endmodule
